// File: design/assert_macros.svh
// shared concurrent assertion forms, clocked and reset-qualified
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AMF_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/amf_pkg.sv
`timescale 1ns / 1ps

package amf_pkg;

  localparam int FIELD_LEN  = 16;
  localparam int NUM_FIELDS = 5;
  localparam int POS_W      = $clog2(FIELD_LEN + 1);
  localparam int FN_W       = 3;

  localparam logic [7:0] CH_START   = 8'h2A;
  localparam logic [7:0] CH_END     = 8'h0A;
  localparam logic [7:0] CH_DELIM   = 8'h7E;
  localparam logic [7:0] ADDR_RESET = 8'd65;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_START   = 2'd1;
  localparam logic [1:0] PH_CAPTURE = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BYTE  = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;
  localparam logic [1:0] EV_ABORT = 2'd3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  typedef struct packed {
    logic [1:0]      phase;
    logic [2:0]      header_count;
    logic [7:0]      first_digit;
    logic [7:0]      second_digit;
    logic [FN_W-1:0] field_number;
    logic [POS_W-1:0] position_in_field;
    logic            last_was_delimiter;
  } state_t;

  // result payload, lowest field declared last
  typedef struct packed {
    logic       pad;
    logic [6:0] command;
    logic       field_overflow;
    logic [3:0] field_pos;
    logic [2:0] field_index;
    logic [7:0] data_byte;
  } out_payload_t;

  typedef struct packed {
    logic [1:0]   event_res;
    out_payload_t payload;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [6:0] decode_command(input logic [7:0] a_chr,
                                                 input logic [7:0] b_chr);
    logic [3:0] a;
    logic [3:0] b;
    a = 4'(a_chr - 8'h30);
    b = 4'(b_chr - 8'h30);
    if (!is_digit(a_chr))
      return 7'd0;
    if (!is_digit(b_chr))
      return 7'(a);
    return 7'({a, 3'b000}) + 7'({a, 1'b0}) + 7'(b);
  endfunction

endpackage

// File: design/amf_step.sv
`timescale 1ns / 1ps

module amf_step (
  input  logic [7:0]       reader_address,
  input  logic             op,
  input  logic [7:0]       rx_byte,
  input  amf_pkg::state_t  cur,
  output amf_pkg::state_t  nxt,
  output amf_pkg::result_t res
);
  import amf_pkg::*;

  state_t           idle_st;
  state_t           base;
  state_t           cap;
  result_t          cap_res;
  logic [POS_W-1:0] pos0;
  logic [FN_W-1:0]  fn;

  assign idle_st = '0;

  // state a capture starts from: running frame, or a fresh frame at the address
  always_comb begin
    base = idle_st;
    if (cur.phase == PH_CAPTURE) begin
      base = cur;
    end else begin
      base.phase             = PH_CAPTURE;
      base.header_count      = 3'd1;
      base.position_in_field = POS_W'(1);
    end
  end

  always_comb begin
    cap     = base;
    cap_res = '0;
    pos0    = base.position_in_field;
    fn      = base.field_number;
    cap_res.event_res = EV_BYTE;
    cap_res.payload.data_byte = rx_byte;
    if (rx_byte == CH_DELIM) begin
      cap.last_was_delimiter = 1'b1;
      cap_res.payload.field_overflow = 1'b0;
    end else begin
      if (base.last_was_delimiter) begin
        cap.last_was_delimiter = 1'b0;
        if (32'(fn) < NUM_FIELDS) begin
          fn   = fn + FN_W'(1);
          pos0 = '0;
        end else begin
          pos0 = POS_W'(FIELD_LEN);
        end
      end
      cap_res.payload.field_overflow = (32'(pos0) >= FIELD_LEN);
      cap.position_in_field = (32'(pos0) < FIELD_LEN) ? pos0 + POS_W'(1) : pos0;
    end
    cap.field_number = fn;
    cap_res.payload.field_index = 3'(fn);
    cap_res.payload.field_pos   = (32'(pos0) > 32'd15) ? 4'hF : 4'(pos0);
    if (base.header_count == 3'd2)
      cap.first_digit = rx_byte;
    else if (base.header_count == 3'd3)
      cap.second_digit = rx_byte;
    if (base.header_count < 3'd4)
      cap.header_count = base.header_count + 3'd1;
  end

  always_comb begin
    nxt = idle_st;
    res = '0;
    if (op == OP_IDLE) begin
      if (cur.phase == PH_CAPTURE)
        res.event_res = EV_ABORT;
    end else begin
      unique case (cur.phase)
        PH_CAPTURE: begin
          if (rx_byte == CH_END) begin
            res.event_res       = EV_DONE;
            res.payload.command = decode_command(cur.first_digit, cur.second_digit);
          end else begin
            nxt = cap;
            res = cap_res;
          end
        end
        PH_START: begin
          if (rx_byte == reader_address) begin
            if (rx_byte == CH_END) begin
              res.event_res = EV_DONE;
            end else begin
              nxt = cap;
              res = cap_res;
            end
          end else if (rx_byte == CH_START) begin
            nxt.phase = PH_START;
          end
        end
        default: begin
          if (rx_byte == CH_START)
            nxt.phase = PH_START;
        end
      endcase
    end
  end

endmodule

// File: design/addressed_message_framer.sv
`timescale 1ns / 1ps

// addressed message framer for a multidrop serial link
// input stream: one transfer per received byte; s_tuser is 0 for a byte in
//   s_tdata, 1 when the receive line went idle (s_tdata then ignored)
// output stream: exactly one transfer per input transfer; m_tuser gives the
//   event (none, captured byte, frame complete, frame aborted), m_tdata the
//   byte, its field number and position, the overflow flag and the command
// config: cfg_wr_en writes cfg_wr_data into the reader address; the user must
//   write it only while the block holds no item in flight (the block does not enforce this)
// timing: the result passes the input register, then the result register fed by
//   one pass of the framing logic
// throughput: one item per cycle while m_tready is high; the running frame state
//   is updated by the same single pass, so back-to-back bytes need no bubbles
// receiver stall: the result register holds; one more item waits in the input
//   register, after which s_tready drops until m_tready returns
// reset: rst (synchronous, active high) empties both stages, holds s_tready
//   low, returns to the start-hunting phase and sets the reader address to 'A'
module addressed_message_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // data_byte[7:0], field_index[10:8], field_pos[14:11],
                                 // field_overflow[15], command[22:16], zero[23]
  output logic [1:0]  m_tuser    // event_res
);
  import amf_pkg::*;

  logic [7:0] reader_addr;
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       advance;
  state_t     st;
  state_t     st_next;
  result_t    step_res;

  // the input stage moves on whenever the result register is free or drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      reader_addr <= ADDR_RESET;
    end else if (cfg_wr_en) begin
      reader_addr <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  amf_step u_step (
    .reader_address (reader_addr),
    .op             (in_op),
    .rx_byte        (in_byte),
    .cur            (st),
    .nxt            (st_next),
    .res            (step_res)
  );

  // frame state follows the item that reaches the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= step_res.payload;
      m_tuser <= step_res.event_res;
    end
  end

endmodule

// File: design/amf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import amf_pkg::*;

  out_payload_t pl;

  assign pl = m_tdata;

  // a stalled result holds
  `AMF_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // byte tags are zero unless a byte was captured
  `AMF_ASSERT_IMPLY(a_tags_zero, clk, rst, m_tvalid && (m_tuser != EV_BYTE),
    (pl.data_byte == 8'd0) && (pl.field_index == 3'd0) && (pl.field_pos == 4'd0)
    && !pl.field_overflow)

  // command only on frame complete, and at most two decimal digits (0 to 99)
  `AMF_ASSERT_IMPLY(a_command, clk, rst, m_tvalid,
    ((m_tuser == EV_DONE) || (pl.command == 7'd0)) && (pl.command <= 7'd99) && !pl.pad)

  // overflowing bytes sit at the saturated position in a legal field
  `AMF_ASSERT_IMPLY(a_overflow, clk, rst, m_tvalid && pl.field_overflow,
    (pl.field_pos == 4'hF) && (32'(pl.field_index) <= NUM_FIELDS))

endmodule

bind addressed_message_framer amf_checker u_amf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
